[design/rmd160_pkg.sv]
// package for the ripemd-160 stream hasher
// holds constants, step tables and the word/result types; no dependencies
`default_nettype none
package rmd160_pkg;
    localparam int QueueDepth = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } in_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_word_t;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hc3d2e1f0;

    function automatic logic [3:0] sel_l(input logic [6:0] j);
        logic [319:0] t;
        t = {4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,
             4'd15,
             4'd7,4'd4,4'd13,4'd1,4'd10,4'd6,4'd15,4'd3,4'd12,4'd0,4'd9,4'd5,4'd2,4'd14,4'd11,
             4'd8,
             4'd3,4'd10,4'd14,4'd4,4'd9,4'd15,4'd8,4'd1,4'd2,4'd7,4'd0,4'd6,4'd13,4'd11,4'd5,
             4'd12,
             4'd1,4'd9,4'd11,4'd10,4'd0,4'd8,4'd12,4'd4,4'd13,4'd3,4'd7,4'd15,4'd14,4'd5,4'd6,
             4'd2,
             4'd4,4'd0,4'd5,4'd9,4'd7,4'd12,4'd2,4'd10,4'd14,4'd1,4'd3,4'd8,4'd11,4'd6,4'd15,
             4'd13};
        return t[319 - 4 * j -: 4];
    endfunction

    function automatic logic [3:0] sel_r(input logic [6:0] j);
        logic [319:0] t;
        t = {4'd5,4'd14,4'd7,4'd0,4'd9,4'd2,4'd11,4'd4,4'd13,4'd6,4'd15,4'd8,4'd1,4'd10,4'd3,
             4'd12,
             4'd6,4'd11,4'd3,4'd7,4'd0,4'd13,4'd5,4'd10,4'd14,4'd15,4'd8,4'd12,4'd4,4'd9,4'd1,
             4'd2,
             4'd15,4'd5,4'd1,4'd3,4'd7,4'd14,4'd6,4'd9,4'd11,4'd8,4'd12,4'd2,4'd10,4'd0,4'd4,
             4'd13,
             4'd8,4'd6,4'd4,4'd1,4'd3,4'd11,4'd15,4'd0,4'd5,4'd12,4'd2,4'd13,4'd9,4'd7,4'd10,
             4'd14,
             4'd12,4'd15,4'd10,4'd4,4'd1,4'd5,4'd8,4'd7,4'd6,4'd2,4'd13,4'd14,4'd0,4'd3,4'd9,
             4'd11};
        return t[319 - 4 * j -: 4];
    endfunction

    function automatic logic [3:0] rot_l(input logic [6:0] j);
        logic [319:0] t;
        t = {4'd11,4'd14,4'd15,4'd12,4'd5,4'd8,4'd7,4'd9,4'd11,4'd13,4'd14,4'd15,4'd6,4'd7,
             4'd9,4'd8,
             4'd7,4'd6,4'd8,4'd13,4'd11,4'd9,4'd7,4'd15,4'd7,4'd12,4'd15,4'd9,4'd11,4'd7,
             4'd13,4'd12,
             4'd11,4'd13,4'd6,4'd7,4'd14,4'd9,4'd13,4'd15,4'd14,4'd8,4'd13,4'd6,4'd5,4'd12,
             4'd7,4'd5,
             4'd11,4'd12,4'd14,4'd15,4'd14,4'd15,4'd9,4'd8,4'd9,4'd14,4'd5,4'd6,4'd8,4'd6,
             4'd5,4'd12,
             4'd9,4'd15,4'd5,4'd11,4'd6,4'd8,4'd13,4'd12,4'd5,4'd12,4'd13,4'd14,4'd11,4'd8,
             4'd5,4'd6};
        return t[319 - 4 * j -: 4];
    endfunction

    function automatic logic [3:0] rot_r(input logic [6:0] j);
        logic [319:0] t;
        t = {4'd8,4'd9,4'd9,4'd11,4'd13,4'd15,4'd15,4'd5,4'd7,4'd7,4'd8,4'd11,4'd14,4'd14,
             4'd12,4'd6,
             4'd9,4'd13,4'd15,4'd7,4'd12,4'd8,4'd9,4'd11,4'd7,4'd7,4'd12,4'd7,4'd6,4'd15,
             4'd13,4'd11,
             4'd9,4'd7,4'd15,4'd11,4'd8,4'd6,4'd6,4'd14,4'd12,4'd13,4'd5,4'd14,4'd13,4'd13,
             4'd7,4'd5,
             4'd15,4'd5,4'd8,4'd11,4'd14,4'd14,4'd6,4'd14,4'd6,4'd9,4'd12,4'd9,4'd12,4'd5,
             4'd15,4'd8,
             4'd8,4'd5,4'd12,4'd9,4'd12,4'd5,4'd14,4'd6,4'd8,4'd13,4'd6,4'd5,4'd15,4'd13,
             4'd11,4'd11};
        return t[319 - 4 * j -: 4];
    endfunction

    function automatic logic [31:0] add_l(input logic [2:0] g);
        case (g)
            3'd0: return 32'h00000000;
            3'd1: return 32'h5a827999;
            3'd2: return 32'h6ed9eba1;
            3'd3: return 32'h8f1bbcdc;
            default: return 32'ha953fd4e;
        endcase
    endfunction

    function automatic logic [31:0] add_r(input logic [2:0] g);
        case (g)
            3'd0: return 32'h50a28be6;
            3'd1: return 32'h5c4dd124;
            3'd2: return 32'h6d703ef3;
            3'd3: return 32'h7a6d76e9;
            default: return 32'h00000000;
        endcase
    endfunction

    function automatic logic [31:0] mix(input logic [2:0] g, input logic [31:0] x,
                                        input logic [31:0] y, input logic [31:0] z);
        case (g)
            3'd0: return x ^ y ^ z;
            3'd1: return (x & y) | (~x & z);
            3'd2: return (x | ~y) ^ z;
            3'd3: return (x & z) | (y & ~z);
            default: return x ^ (y | ~z);
        endcase
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [3:0] n);
        logic [63:0] d;
        d = {v, v} << n;
        return d[63:32];
    endfunction
endpackage
`default_nettype wire

[design/rmd160_if.sv]
// valid/ready channel carrying one payload word
// depends on nothing; payload type is a parameter
`default_nettype none
interface rmd160_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[design/rmd160_queue.sv]
// short fifo between the byte front end and the compression back end
// depends on rmd160_pkg
`default_nettype none
module rmd160_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire rmd160_pkg::in_word_t push_data,
    output logic                      full,
    input  wire logic                 pop,
    output rmd160_pkg::in_word_t      pop_data,
    output logic                      empty
);
    import rmd160_pkg::*;
    localparam int AW = $clog2(QueueDepth);
    in_word_t       mem_reg [QueueDepth];
    logic [AW-1:0]  wr_reg, rd_reg;
    logic [AW:0]    cnt_reg;

    assign full     = cnt_reg == (AW+1)'(QueueDepth);
    assign empty    = cnt_reg == '0;
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

[design/rmd160_engine.sv]
// back end: block store, padding, 80-step two-line compression and digest output
// depends on rmd160_pkg
`default_nettype none
module rmd160_engine (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_empty,
    input  wire rmd160_pkg::in_word_t  q_data,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output rmd160_pkg::out_word_t      out_data
);
    import rmd160_pkg::*;

    localparam logic [2:0] S_TAKE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_RUN  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]   state_reg;
    logic [5:0]   fill_reg;
    logic [63:0]  len_reg;
    logic         final_reg;
    logic         lenblk_reg;
    logic         done_reg;
    logic [6:0]   step_reg;
    logic [2:0]   widx_reg;
    logic [31:0]  w_reg [16];
    logic [31:0]  h_reg [5];
    logic [31:0]  la_reg, lb_reg, lc_reg, ld_reg, le_reg;
    logic [31:0]  ra_reg, rb_reg, rc_reg, rd_reg, re_reg;

    logic [2:0]   grp;
    logic [31:0]  tl, tr;
    logic [31:0]  pad_word;
    logic [63:0]  len_next;

    assign grp   = (step_reg < 7'd16) ? 3'd0 : (step_reg < 7'd32) ? 3'd1 :
                   (step_reg < 7'd48) ? 3'd2 : (step_reg < 7'd64) ? 3'd3 : 3'd4;
    assign tl    = rotl(la_reg + mix(grp, lb_reg, lc_reg, ld_reg) + w_reg[sel_l(step_reg)]
                   + add_l(grp), rot_l(step_reg)) + le_reg;
    assign tr    = rotl(ra_reg + mix(3'd4 - grp, rb_reg, rc_reg, rd_reg)
                   + w_reg[sel_r(step_reg)] + add_r(grp), rot_r(step_reg)) + re_reg;
    assign q_pop = (state_reg == S_TAKE) && !q_empty;
    assign len_next = len_reg + {60'd0, q_data.byte_valid, 3'b000};

    assign out_valid = state_reg == S_EMIT;
    assign out_data.digest_word = h_reg[widx_reg];
    assign out_data.word_index  = widx_reg;
    assign out_data.last_word   = widx_reg == 3'd4;

    always_comb
    begin
        pad_word = w_reg[fill_reg[5:2]];
        case (fill_reg[1:0])
            2'd0: pad_word = 32'h00000080;
            2'd1: pad_word = {16'h0, 8'h80, pad_word[7:0]};
            2'd2: pad_word = {8'h0, 8'h80, pad_word[15:0]};
            default: pad_word = {8'h80, pad_word[23:0]};
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_TAKE:
            begin
                if (q_pop && q_data.byte_valid)
                begin
                    w_reg[fill_reg[5:2]][8*fill_reg[1:0] +: 8] <= q_data.data_byte;
                end
            end
            S_PAD:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    if (i >= 14 && (lenblk_reg || fill_reg < 6'd56))
                    begin
                        w_reg[i] <= (i == 14) ? len_reg[31:0] : len_reg[63:32];
                    end
                    else if (lenblk_reg)
                    begin
                        w_reg[i] <= '0;
                    end
                    else if (4'(i) == fill_reg[5:2])
                    begin
                        w_reg[i] <= pad_word;
                    end
                    else if (4'(i) > fill_reg[5:2])
                    begin
                        w_reg[i] <= '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_RUN)
        begin
            la_reg <= le_reg; le_reg <= ld_reg; ld_reg <= rotl(lc_reg, 4'd10);
            lc_reg <= lb_reg; lb_reg <= tl;
            ra_reg <= re_reg; re_reg <= rd_reg; rd_reg <= rotl(rc_reg, 4'd10);
            rc_reg <= rb_reg; rb_reg <= tr;
        end
        else
        begin
            la_reg <= h_reg[0]; lb_reg <= h_reg[1]; lc_reg <= h_reg[2];
            ld_reg <= h_reg[3]; le_reg <= h_reg[4];
            ra_reg <= h_reg[0]; rb_reg <= h_reg[1]; rc_reg <= h_reg[2];
            rd_reg <= h_reg[3]; re_reg <= h_reg[4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_TAKE;
            fill_reg   <= '0;
            len_reg    <= '0;
            final_reg  <= 1'b0;
            lenblk_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
            widx_reg   <= '0;
            h_reg[0] <= H0; h_reg[1] <= H1; h_reg[2] <= H2; h_reg[3] <= H3; h_reg[4] <= H4;
        end
        else
        begin
            case (state_reg)
                S_TAKE:
                begin
                    if (q_pop)
                    begin
                        len_reg   <= len_next;
                        final_reg <= q_data.end_of_message;
                        step_reg  <= '0;
                        if (q_data.byte_valid)
                        begin
                            fill_reg <= fill_reg + 6'd1;
                        end
                        if (q_data.byte_valid && fill_reg == 6'd63)
                        begin
                            state_reg <= S_RUN;
                        end
                        else if (q_data.end_of_message)
                        begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    step_reg <= '0;
                    state_reg <= S_RUN;
                    if (!lenblk_reg && fill_reg >= 6'd56)
                    begin
                        lenblk_reg <= 1'b1;
                    end
                    else
                    begin
                        lenblk_reg <= 1'b0;
                        final_reg  <= 1'b0;
                        widx_reg   <= '0;
                        done_reg   <= 1'b1;
                    end
                end
                S_RUN:
                begin
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == 7'd79)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    h_reg[0] <= h_reg[1] + lc_reg + rd_reg;
                    h_reg[1] <= h_reg[2] + ld_reg + re_reg;
                    h_reg[2] <= h_reg[3] + le_reg + ra_reg;
                    h_reg[3] <= h_reg[4] + la_reg + rb_reg;
                    h_reg[4] <= h_reg[0] + lb_reg + rc_reg;
                    if (final_reg || lenblk_reg)
                    begin
                        state_reg <= S_PAD;
                    end
                    else if (done_reg)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_TAKE;
                    end
                end
                S_EMIT:
                begin
                    if (out_ready)
                    begin
                        if (widx_reg == 3'd4)
                        begin
                            widx_reg  <= '0;
                            done_reg  <= 1'b0;
                            state_reg <= S_TAKE;
                            fill_reg  <= '0;
                            len_reg   <= '0;
                            h_reg[0] <= H0; h_reg[1] <= H1; h_reg[2] <= H2;
                            h_reg[3] <= H3; h_reg[4] <= H4;
                        end
                        else
                        begin
                            widx_reg <= widx_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_TAKE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[design/ripemd160_stream_hasher_core.sv]
// ripemd-160 stream hasher top level: byte queue front and compression back end
// depends on rmd160_pkg, rmd160_if, rmd160_queue, rmd160_engine
//
// usage: message bytes enter one word at a time on in_ch (data_byte, byte_valid,
// end_of_message); a word with byte_valid low and end_of_message low is ignored.
// the front end buffers words in a four-entry queue, so in_ch takes up to four
// words while a block is compressed. the back end takes one word per cycle while
// it fills a block; every 64th byte starts one compression of 80 steps of the
// two-line round unit plus a fold into the chaining words, which does not overlap
// filling, so the back end takes no word while a block is compressed. the end word
// pads the block (one or two extra compressions); the first digest word is ready
// when the last compression is folded, after one more compression when the
// length needs a block of its own. five digest words then leave on
// out_ch, one per cycle, index 0 first, last_word on index 4; each waits while
// out_ready is low, and the queue fills behind it. reset loads the standard
// initial chaining words and clears the fill position, length and queue; the
// block then starts a new message.
`default_nettype none
module ripemd160_stream_hasher_core (
    input  wire logic clk,
    input  wire logic rst_n,
    rmd160_if.sink    in_ch,
    rmd160_if.source  out_ch
);
    import rmd160_pkg::*;
    logic     full, empty, pop;
    in_word_t qd;
    in_word_t pd;

    assign pd.data_byte      = in_ch.payload.data_byte;
    assign pd.byte_valid     = in_ch.payload.byte_valid;
    assign pd.end_of_message = in_ch.payload.end_of_message;
    assign in_ch.ready = !full;

    rmd160_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(in_ch.valid && !full && (pd.byte_valid || pd.end_of_message)),
        .push_data(pd), .full(full),
        .pop(pop), .pop_data(qd), .empty(empty)
    );

    rmd160_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .q_empty(empty), .q_data(qd), .q_pop(pop),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.payload)
    );
endmodule
`default_nettype wire

[tb/sv/tb_ripemd160_stream_hasher_core.sv]
// testbench for the ripemd-160 stream hasher: random and directed messages,
// digests predicted by a local model and checked word by word
// depends on rmd160_pkg, rmd160_if and ripemd160_stream_hasher_core
`timescale 1ns / 100ps
`default_nettype none
module tb_ripemd160_stream_hasher_core;
    import rmd160_pkg::*;

    localparam int StepLimit = 2000000;

    class digest_board;
        logic [31:0] chain [5];
        logic [7:0]  blk [64];
        int          fill;
        logic [63:0] bit_len;
        out_word_t   pending [$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            chain[0] = 32'h67452301;
            chain[1] = 32'hefcdab89;
            chain[2] = 32'h98badcfe;
            chain[3] = 32'h10325476;
            chain[4] = 32'hc3d2e1f0;
            fill = 0;
            bit_len = '0;
        endfunction

        function logic [31:0] rol(logic [31:0] v, int n);
            return (n == 0) ? v : ((v << n) | (v >> (32 - n)));
        endfunction

        function logic [31:0] boolean_fn(int g, logic [31:0] x, logic [31:0] y,
                                         logic [31:0] z);
            case (g)
                0: return x ^ y ^ z;
                1: return (x & y) | (~x & z);
                2: return (x | ~y) ^ z;
                3: return (x & z) | (y & ~z);
                default: return x ^ (y | ~z);
            endcase
        endfunction

        function void compress_block();
            int          wl [80];
            int          wr [80];
            int          sl [80];
            int          sr [80];
            logic [31:0] kl [5];
            logic [31:0] kr [5];
            logic [31:0] w [16];
            logic [31:0] la, lb, lc, ld, le, ra, rb, rc, rd, re, t;
            int          g;
            wl = '{0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
                   7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
                   3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
                   1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
                   4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13};
            wr = '{5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
                   6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
                   15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
                   8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
                   12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11};
            sl = '{11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
                   7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
                   11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
                   11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
                   9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6};
            sr = '{8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
                   9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
                   9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
                   15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
                   8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11};
            kl = '{32'h0, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'ha953fd4e};
            kr = '{32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3, 32'h7a6d76e9, 32'h0};
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
            la = chain[0]; lb = chain[1]; lc = chain[2]; ld = chain[3]; le = chain[4];
            ra = la; rb = lb; rc = lc; rd = ld; re = le;
            for (int j = 0; j < 80; j++)
            begin
                g = j / 16;
                t = rol(la + boolean_fn(g, lb, lc, ld) + w[wl[j]] + kl[g], sl[j]) + le;
                la = le; le = ld; ld = rol(lc, 10); lc = lb; lb = t;
                t = rol(ra + boolean_fn(4 - g, rb, rc, rd) + w[wr[j]] + kr[g], sr[j]) + re;
                ra = re; re = rd; rd = rol(rc, 10); rc = rb; rb = t;
            end
            t = chain[1] + lc + rd;
            chain[1] = chain[2] + ld + re;
            chain[2] = chain[3] + le + ra;
            chain[3] = chain[4] + la + rb;
            chain[4] = chain[0] + lb + rc;
            chain[0] = t;
        endfunction

        function void note_input(in_word_t wd);
            int        pos;
            out_word_t r;
            if (wd.byte_valid)
            begin
                blk[fill] = wd.data_byte;
                fill++;
                bit_len += 64'd8;
                if (fill == 64)
                begin
                    compress_block();
                    fill = 0;
                end
            end
            if (!wd.end_of_message)
                return;
            pos = fill;
            blk[pos] = 8'h80;
            pos++;
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    blk[pos] = 8'h00;
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < 56)
            begin
                blk[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++)
                blk[56 + i] = bit_len[8*i +: 8];
            compress_block();
            for (int i = 0; i < 5; i++)
            begin
                r.digest_word = chain[i];
                r.word_index = i[2:0];
                r.last_word = (i == 4);
                pending.push_back(r);
            end
            restart();
        endfunction

        function void check_result(out_word_t got);
            out_word_t exp_w;
            if (pending.size() == 0)
            begin
                $error("unexpected digest word %h", got.digest_word);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.digest_word !== exp_w.digest_word)
            begin
                $error("digest_word: expected %h, got %h", exp_w.digest_word,
                       got.digest_word);
                errors++;
            end
            if (got.word_index !== exp_w.word_index)
            begin
                $error("word_index: expected %0d, got %0d", exp_w.word_index,
                       got.word_index);
                errors++;
            end
            if (got.last_word !== exp_w.last_word)
            begin
                $error("last_word: expected %0d, got %0d", exp_w.last_word, got.last_word);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;
    int   cycle_count;
    digest_board board;

    rmd160_if #(.payload_t(in_word_t))  in_ch ();
    rmd160_if #(.payload_t(out_word_t)) out_ch ();

    ripemd160_stream_hasher_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        board = new();
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        calm = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            board.note_input(in_ch.payload);
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_result(out_ch.payload);
    end

    // receiver stalls in bursts
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                n = $urandom_range(1, 11);
                repeat (n - 1) @(posedge clk);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > StepLimit)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial cycle_count = 0;

    task automatic send_word(input logic [7:0] b, input logic bv, input logic eom);
        int n;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_ch.valid <= 1'b0;
            n = $urandom_range(1, 11);
            repeat (n) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= '{data_byte: b, byte_valid: bv, end_of_message: eom};
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic send_message(input int len, input bit end_alone);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_word(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !end_alone);
        end
        if (end_alone || len == 0)
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int sent;
        int len;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: empty message, idle word, field extremes, pad boundaries
        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hff, 1'b1, 1'b1);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        send_message(2, 1'b1);
        drain();
        send_message(55, 1'b0);
        send_message(56, 1'b0);
        send_message(63, 1'b1);
        send_message(64, 1'b0);
        // long message over two blocks, then a pause until all digests arrive
        send_message(66, 1'b1);
        drain();
        sent = 0;
        while (sent < 40)
        begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20)
                                              : $urandom_range(0, 8);
            if (sent > 20)
                calm = 1'b1;
            send_message(len, 1'($urandom_range(0, 1)));
            sent += len + 1;
        end
        drain();
        repeat (400) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
